// ----- rtl/ktafr_pkg.sv -----
// ----------------------------------------------------------------------------
// ktafr_pkg
// Shared types and constants for the keyed table with add, find and remove.
// ----------------------------------------------------------------------------
package ktafr_pkg;

  // Table size and the index and count widths that follow from it
  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // Fixed field widths
  localparam int KeyW   = 16;
  localparam int SeatW  = 16;
  localparam int SlotW  = 6;
  localparam int CountW = 7;
  localparam int TotalW = 22;
  localparam int RunW   = 23;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [SeatW-1:0] seats;
  } entry_t;

  // Table memory access, one write and one read port
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

// ----- rtl/keyed_table_add_find_remove_unit.sv -----
// Sequence: add passes through S_ADD to S_FIN, where the result is loaded; clear goes
// straight to S_FIN; find and remove walk the table one key compare per cycle through
// the single memory read port, and remove adds the S_MOVE state to move the last entry
// into the hole. A result register still held by the sink keeps the sequencer in S_FIN.
// Throughput: one transaction at a time; the next input is taken once the sequencer is
// back in idle, the cycle after the result is loaded, even while that result waits.
// ----------------------------------------------------------------------------
// keyed_table_add_find_remove_unit
// Packed key/seat table with add, find, remove (swap with last) and clear,
// run by a small sequencer around one memory and one key comparator.
// Reset: count and seat total clear at once; the memory is not cleared.
// ----------------------------------------------------------------------------
module keyed_table_add_find_remove_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ktafr_pkg::op_e                      op_i,
  input  logic [ktafr_pkg::KeyW-1:0]          entry_key_i,
  input  logic [ktafr_pkg::SeatW-1:0]         entry_seats_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ktafr_pkg::status_e                  status_o,
  output logic [ktafr_pkg::SlotW-1:0]         slot_index_o,
  output logic [ktafr_pkg::SeatW-1:0]         found_seats_o,
  output logic [ktafr_pkg::CountW-1:0]        entry_count_o,
  output logic [ktafr_pkg::TotalW-1:0]        seat_total_o
);
  import ktafr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_MOVE = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Control state
  logic [CntW-1:0] count_q, count_d;
  logic [RunW-1:0] total_q, total_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;

  // Per-transaction working registers
  op_e              op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [SeatW-1:0] seats_q, seats_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  status_e          status_q, status_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SeatW-1:0] fseats_q, fseats_d;

  // Output registers
  logic             load_out;
  status_e          status_out_q;
  logic [SlotW-1:0] slot_out_q;
  logic [SeatW-1:0] fseats_out_q;
  logic [CountW-1:0] count_out_q;
  logic [TotalW-1:0] total_out_q;

  mem_req_t        mem_req;
  entry_t          rd_data;
  logic [CntW-1:0] last_cnt;
  logic [IdxW-1:0] last_idx;

  ktafr_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_data)
  );

  assign last_cnt = count_q - CntW'(1);
  assign last_idx = last_cnt[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    op_d        = op_q;
    key_d       = key_q;
    seats_d     = seats_q;
    cmp_idx_d   = cmp_idx_q;
    hit_idx_d   = hit_idx_q;
    status_d    = status_q;
    slot_d      = slot_q;
    fseats_d    = fseats_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          key_d    = entry_key_i;
          seats_d  = entry_seats_i;
          status_d = ST_OK;
          slot_d   = '0;
          fseats_d = '0;
          idx_d    = '0;
          pend_d   = 1'b0;
          unique case (op_i)
            OP_ADD:               state_d = S_ADD;
            OP_FIND, OP_REMOVE:   state_d = S_SCAN;
            OP_CLEAR: begin
              count_d = '0;
              total_d = '0;
              state_d = S_FIN;
            end
            default:              state_d = S_FIN;
          endcase
        end
      end
      S_ADD: begin
        if (count_q == CntW'(TableDepth)) begin
          status_d = ST_FULL;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = count_q[IdxW-1:0];
          mem_req.wdata = '{key: key_q, seats: seats_q};
          slot_d        = SlotW'(count_q);
          count_d       = count_q + CntW'(1);
          total_d       = total_q + RunW'(seats_q);
        end
        state_d = S_FIN;
      end
      S_SCAN: begin
        // read of slot idx_q issued each cycle, compared the cycle after
        pend_d = 1'b0;
        if (pend_q && (rd_data.key == key_q)) begin
          if (op_q == OP_FIND) begin
            slot_d   = SlotW'(cmp_idx_q);
            fseats_d = rd_data.seats;
            state_d  = S_FIN;
          end else begin
            hit_idx_d     = cmp_idx_q;
            total_d       = total_q - RunW'(rd_data.seats);
            mem_req.re    = 1'b1;
            mem_req.raddr = last_idx;
            count_d       = last_cnt;
            state_d       = S_MOVE;
          end
        end else if (idx_q == count_q) begin
          status_d = ST_MISSING;
          state_d  = S_FIN;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q[IdxW-1:0];
          cmp_idx_d     = idx_q[IdxW-1:0];
          idx_d         = idx_q + CntW'(1);
          pend_d        = 1'b1;
        end
      end
      S_MOVE: begin
        // last entry fills the hole
        mem_req.we    = 1'b1;
        mem_req.waddr = hit_idx_q;
        mem_req.wdata = rd_data;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    seats_q   <= seats_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    status_q  <= status_d;
    slot_q    <= slot_d;
    fseats_q  <= fseats_d;
    if (load_out) begin
      status_out_q <= status_q;
      slot_out_q   <= slot_q;
      fseats_out_q <= fseats_q;
      count_out_q  <= CountW'(count_q);
      total_out_q  <= total_q[TotalW-1:0];
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_out_q;
  assign slot_index_o  = slot_out_q;
  assign found_seats_o = fseats_out_q;
  assign entry_count_o = count_out_q;
  assign seat_total_o  = total_out_q;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count above table depth");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({status_o, slot_index_o, found_seats_o, entry_count_o, seat_total_o}))
    else $error("result dropped or changed while stalled");

  a_read_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && mem_req.re && (state_d == S_SCAN) |-> (idx_q < count_q))
    else $error("scan read beyond entries in use");

  a_empty_zero_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (total_q == '0))
    else $error("nonzero seat total with empty table");

  a_add_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) && mem_req.we |=> (count_q != '0))
    else $error("add wrote but count is zero");

endmodule

// ----- rtl/ktafr_store.sv -----
// ----------------------------------------------------------------------------
// ktafr_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ktafr_store (
  input  logic               clk_i,
  input  ktafr_pkg::mem_req_t req_i,
  output ktafr_pkg::entry_t   rdata_o
);
  import ktafr_pkg::*;

  entry_t mem_q [TableDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- bench/tb_keyed_table_add_find_remove_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_table_add_find_remove_unit
// Self-checking bench for the keyed seat table. A scoreboard class keeps its
// own copy of the table, predicts each result on acceptance and compares
// every returned transaction. The sender runs directed corner cases, then
// random fill/search/remove episodes. Both sides idle at random, with one
// long output hold-off and some full drains.
// ----------------------------------------------------------------------------
module tb_keyed_table_add_find_remove_unit;
  import ktafr_pkg::*;

  localparam int unsigned RandomItems = 1830;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = TableDepth + 16;
  localparam int unsigned LimitCycles = 1_000_000;

  typedef struct packed {
    status_e            status;
    logic [SlotW-1:0]   slot;
    logic [SeatW-1:0]   seats;
    logic [CountW-1:0]  count;
    logic [TotalW-1:0]  total;
  } table_result_t;

  class seat_table_board;
    logic [KeyW-1:0]  keys  [TableDepth];
    logic [SeatW-1:0] seats [TableDepth];
    int unsigned      used;
    logic [RunW-1:0]  total;
    table_result_t    due_results[$];
    int unsigned      errors, accepted, checked;
    int unsigned      op_tally[4];
    int unsigned      full_hits, miss_hits, peak_used;

    function new();
      used = 0;
      total = '0;
    endfunction

    // lowest slot below the count holding key, or -1
    function int locate(logic [KeyW-1:0] key);
      for (int i = 0; i < int'(used); i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function logic [KeyW-1:0] live_key();
      if (used == 0) return KeyW'($urandom);
      return keys[$urandom_range(0, used - 1)];
    endfunction

    function void note_request(op_e op, logic [KeyW-1:0] key, logic [SeatW-1:0] seat);
      table_result_t r;
      int hit;
      r.status = ST_OK;
      r.slot   = '0;
      r.seats  = '0;
      accepted++;
      op_tally[int'(op)]++;
      case (op)
        OP_ADD: begin
          if (used >= TableDepth) begin
            r.status = ST_FULL;
            full_hits++;
          end else begin
            r.slot      = SlotW'(used);
            keys[used]  = key;
            seats[used] = seat;
            used++;
            total = total + RunW'(seat);
          end
        end
        OP_FIND: begin
          hit = locate(key);
          if (hit < 0) begin
            r.status = ST_MISSING;
            miss_hits++;
          end else begin
            r.slot  = SlotW'(hit);
            r.seats = seats[hit];
          end
        end
        OP_REMOVE: begin
          hit = locate(key);
          if (hit < 0) begin
            r.status = ST_MISSING;
            miss_hits++;
          end else begin
            // swap-remove: last entry fills the hole
            total      = total - RunW'(seats[hit]);
            keys[hit]  = keys[used - 1];
            seats[hit] = seats[used - 1];
            used--;
          end
        end
        default: begin
          used  = 0;
          total = '0;
        end
      endcase
      if (used > peak_used) peak_used = used;
      r.count = CountW'(used);
      r.total = total[TotalW-1:0];
      due_results.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] result with nothing pending: ",
                    "status %0d slot %0d seats %h count %0d total %0d"},
                   $time, got.status, got.slot, got.seats, got.count, got.total);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.status !== want.status || got.slot !== want.slot || got.seats !== want.seats ||
          got.count !== want.count || got.total !== want.total) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] mismatch on result %0d (exp/got): status %0d/%0d ",
                    "slot %0d/%0d seats %h/%h count %0d/%0d total %0d/%0d"},
                   $time, checked, want.status, got.status, want.slot, got.slot,
                   want.seats, got.seats, want.count, got.count, want.total, got.total);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  op_e                 op_i;
  logic [KeyW-1:0]     entry_key_i;
  logic [SeatW-1:0]    entry_seats_i;
  logic                out_valid_o;
  logic                out_ready_i;
  status_e             status_o;
  logic [SlotW-1:0]    slot_index_o;
  logic [SeatW-1:0]    found_seats_o;
  logic [CountW-1:0]   entry_count_o;
  logic [TotalW-1:0]   seat_total_o;

  seat_table_board sb;
  bit              hold_req;
  bit              no_gaps;
  int unsigned     burst_left = 1;

  keyed_table_add_find_remove_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_key_i   (entry_key_i),
    .entry_seats_i (entry_seats_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .found_seats_o (found_seats_o),
    .entry_count_o (entry_count_o),
    .seat_total_o  (seat_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [KeyW-1:0] rand_key();
    return KeyW'($urandom);
  endfunction

  function automatic logic [SeatW-1:0] rand_seats();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return SeatW'($urandom);
  endfunction

  // mostly keys that are in the table, so searches land at random depths
  function automatic logic [KeyW-1:0] probe_key();
    if ($urandom_range(0, 4) != 0) return sb.live_key();
    return rand_key();
  endfunction

  // one transaction, then a random gap once the current burst runs out
  task automatic offer(op_e op, logic [KeyW-1:0] key, logic [SeatW-1:0] seats);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    op_i          <= op;
    entry_key_i   <= key;
    entry_seats_i <= seats;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, key, seats);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    if (sb.due_results.size() != 0) begin
      in_valid_i <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic mixed_run(int unsigned len);
    int unsigned pick;
    repeat (len) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)
        offer(OP_ADD, (pick < 8) ? sb.live_key() : rand_key(), rand_seats());
      else if (pick < 68)
        offer(OP_FIND, probe_key(), rand_seats());
      else if (pick < 97)
        offer(OP_REMOVE, probe_key(), rand_seats());
      else
        offer(OP_CLEAR, rand_key(), rand_seats());
    end
  endtask

  task automatic run_episodes(int unsigned n);
    int unsigned goal;
    int unsigned kind;
    goal = sb.accepted + n;
    while (sb.accepted < goal) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        // fill to the top, knock on it a few times, then churn a full table
        while (sb.used < TableDepth) offer(OP_ADD, rand_key(), rand_seats());
        repeat ($urandom_range(1, 3)) offer(OP_ADD, rand_key(), rand_seats());
        mixed_run($urandom_range(10, 40));
      end else if (kind == 2) begin
        offer(OP_CLEAR, rand_key(), rand_seats());
      end else begin
        mixed_run($urandom_range(10, 60));
      end
    end
  endtask

  task automatic run_directed();
    offer(OP_FIND,   16'h0000, 16'h0000);  // empty table
    offer(OP_REMOVE, 16'hFFFF, 16'hFFFF);
    offer(OP_CLEAR,  16'hFFFF, 16'hFFFF);
    offer(OP_ADD,    16'h0000, 16'h0000);
    offer(OP_ADD,    16'hFFFF, 16'hFFFF);
    offer(OP_ADD,    16'h1234, 16'h0005);
    offer(OP_ADD,    16'h1234, 16'h0007);  // duplicate key
    offer(OP_ADD,    16'hA5A5, 16'h5A5A);
    offer(OP_FIND,   16'h1234, 16'h0000);  // lowest duplicate wins
    offer(OP_FIND,   16'hFFFF, 16'h0000);
    offer(OP_FIND,   16'h0000, 16'hFFFF);
    offer(OP_FIND,   16'hBEEF, 16'h0000);
    offer(OP_REMOVE, 16'h1234, 16'h0000);  // last entry moves into slot 2
    offer(OP_FIND,   16'hA5A5, 16'h0000);
    offer(OP_FIND,   16'h1234, 16'h0000);
    offer(OP_REMOVE, 16'h0000, 16'hFFFF);
    offer(OP_REMOVE, 16'hA5A5, 16'h0000);  // match is the last slot
    offer(OP_REMOVE, 16'hBEEF, 16'h0000);
    offer(OP_FIND,   16'hFFFF, 16'h0000);
    offer(OP_CLEAR,  16'h0000, 16'h0000);
    offer(OP_FIND,   16'hFFFF, 16'h0000);
    offer(OP_ADD,    16'h5A5A, 16'hFFFF);
  endtask

  // receiver: random stall segments, plus one long hold-off on request
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned phase;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    phase = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 160);
      while (seg != 0 && !hold_req) begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((phase % 7) < 4);
        endcase
        phase++;
        seg--;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{status: status_o, slot: slot_index_o, seats: found_seats_o,
                        count: entry_count_o, total: seat_total_o});
  end

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = OP_ADD;
    entry_key_i   = '0;
    entry_seats_i = '0;
    hold_req      = 1'b0;
    no_gaps       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    run_episodes(RandomItems / 3);
    // keep offering with no gaps while the output is held off
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    mixed_run(60);
    no_gaps  = 1'b0;
    run_episodes(RandomItems / 3);
    wait_drained();
    run_episodes(RandomItems - 2 * (RandomItems / 3) - 60);

    wait_drained();
    in_valid_i <= 1'b0;
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d transactions: %0d add, %0d find, %0d remove, %0d clear",
             sb.accepted, sb.op_tally[0], sb.op_tally[1], sb.op_tally[2], sb.op_tally[3]);
    $display({"%0d results checked; table peaked at %0d entries, %0d adds hit a full ",
              "table, %0d lookups missed, %0d failures"},
             sb.checked, sb.peak_used, sb.full_hits, sb.miss_hits, sb.errors);
    if (sb.errors == 0)
      $display("tb_keyed_table_add_find_remove_unit: done, clean");
    else
      $display("tb_keyed_table_add_find_remove_unit: done, errors");
    $finish;
  end

  initial begin
    #(LimitCycles * 4);
    $display("timeout with %0d results outstanding", sb.due_results.size());
    $display("tb_keyed_table_add_find_remove_unit: done, errors");
    $finish;
  end

endmodule
